/* rtl/pta_pkg.sv */
package pta_pkg;

   localparam int PEER_SLOTS_DEF = 32;
   localparam int RESULT_CAP     = 32;
   localparam int LOST_W         = $clog2(RESULT_CAP + 1);
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 48;
   localparam logic [31:0] EXPIRY_RESET = 32'd15000;

   typedef enum logic [1:0] {
      CMD_ANNOUNCE = 2'd0,
      CMD_PROBE    = 2'd1,
      CMD_SWEEP    = 2'd2,
      CMD_LOOKUP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_DISCOVERED = 3'd0,
      KIND_REFRESHED  = 3'd1,
      KIND_LOST       = 3'd2,
      KIND_DEFEND     = 3'd3,
      KIND_HIT        = 3'd4,
      KIND_MISS       = 3'd5,
      KIND_FULL       = 3'd6,
      KIND_NOTHING    = 3'd7
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SELF_UID = 2'd0,
      CSR_SELF_MAC = 2'd1,
      CSR_EXPIRY   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRAP
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] uid;
      logic [47:0] mac;
      logic [7:0]  dev_code;
      logic        clock_slave;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] peer_id;
      logic [47:0] peer_mac;
      logic [7:0]  peer_type;
      logic        peer_clock_slave;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] uid;
      logic [47:0] mac;
      logic [7:0]  dev_code;
      logic        slave;
      logic [31:0] stamp;
   } slot_entry_type;

endpackage

/* rtl/peer_table_with_aging.sv */
// channel  ports                                   handshake
// req      start, busy, req_word                   word taken when start & !busy
// rsp      rsp_valid, rsp_word                     one word per cycle strobed by rsp_valid
// csr      csr_valid, csr_ready, csr_index, csr_wdata  write when csr_valid & csr_ready
//
// Sweep, lookup and any announce not defended walk the slot memory one entry per cycle,
// paced by the single memory read port. Probe and announce defending our uid skip the
// walk and go straight to the wrap state, where the final result is registered.
// Reset clears slot valid flops and control state at once; no clearing pass.
// No rsp backpressure; sweep emits a lost peer when the next is found, last at wrap.
module peer_table_with_aging #(
   parameter int PEER_SLOTS = pta_pkg::PEER_SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  pta_pkg::req_type                   req_word,
   output logic                               rsp_valid,
   output pta_pkg::rsp_type                   rsp_word,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pta_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pta_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pta_pkg::*;

   localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int CNT_W = $clog2(PEER_SLOTS + 1);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [15:0]          self_uid_ff;
   logic [47:0]          self_mac_ff;
   logic [31:0]          expiry_ff;
   logic [PEER_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   slot_entry_type       rd_ff;
   logic                 hit_vld_ff, hit_vld_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   slot_entry_type       hit_ff, hit_in;
   logic                 free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 pend_vld_ff, pend_vld_in;
   rsp_type              pend_ff, pend_in;
   logic [LOST_W-1:0]    lost_cnt_ff, lost_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   slot_entry_type       slot_mem [PEER_SLOTS];
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   slot_entry_type       mem_wd;

   logic                 rd_en;
   logic                 in_wrap;
   logic                 accept;
   logic                 skip_scan;
   logic                 ev_live;
   logic [31:0]          idle_ms;
   logic                 expired;
   logic                 match;
   logic                 def_ann;
   logic                 def_probe;

   function automatic rsp_type make_rsp(kind_type k, logic [15:0] u, logic [47:0] m,
                                        logic [7:0] t, logic s, logic l);
      rsp_type r;
      r.kind             = k;
      r.peer_id          = u;
      r.peer_mac         = m;
      r.peer_type        = t;
      r.peer_clock_slave = s;
      r.last             = l;
      return r;
   endfunction

   assign accept    = start && !busy;
   assign skip_scan = (req_word.cmd == CMD_PROBE) ||
                      (req_word.cmd == CMD_ANNOUNCE && req_word.uid == self_uid_ff &&
                       req_word.mac != self_mac_ff && req_word.mac != 48'd0);

   // shared compare unit on the registered read word
   assign ev_live = valid_ff[ev_idx_ff];
   assign idle_ms = req_ff.now_ms - rd_ff.stamp;
   assign expired = ev_live && (idle_ms > expiry_ff);
   assign match   = ev_live && (rd_ff.uid == req_ff.uid);

   assign def_probe = (req_ff.uid == self_uid_ff) && (req_ff.mac != self_mac_ff);
   assign def_ann   = def_probe && (req_ff.mac != 48'd0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = skip_scan ? ST_WRAP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == CNT_W'(PEER_SLOTS) && !ev_vld_ff) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy    = 1'b1;
      rd_en   = 1'b0;
      in_wrap = 1'b0;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_SCAN: rd_en = (scan_ff < CNT_W'(PEER_SLOTS));
         ST_WRAP: in_wrap = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      valid_in     = valid_ff;
      scan_in      = scan_ff;
      ev_vld_in    = 1'b0;
      ev_idx_in    = ev_idx_ff;
      hit_vld_in   = hit_vld_ff;
      hit_idx_in   = hit_idx_ff;
      hit_in       = hit_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      lost_cnt_in  = lost_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = free_idx_ff;
      mem_wd.uid      = req_ff.uid;
      mem_wd.mac      = req_ff.mac;
      mem_wd.dev_code = req_ff.dev_code;
      mem_wd.slave    = req_ff.clock_slave;
      mem_wd.stamp    = req_ff.now_ms;

      if (accept) begin
         req_in      = req_word;
         scan_in     = '0;
         hit_vld_in  = 1'b0;
         free_vld_in = 1'b0;
         pend_vld_in = 1'b0;
         lost_cnt_in = '0;
      end

      if (rd_en) begin
         scan_in   = scan_ff + 1'b1;
         ev_vld_in = 1'b1;
         ev_idx_in = scan_ff[IDX_W-1:0];
      end

      if (ev_vld_ff) begin
         if (req_ff.cmd == CMD_SWEEP) begin
            if (expired && lost_cnt_ff < LOST_W'(RESULT_CAP)) begin
               valid_in[ev_idx_ff] = 1'b0;
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_vld_in = 1'b1;
               pend_in     = make_rsp(KIND_LOST, rd_ff.uid, rd_ff.mac, rd_ff.dev_code,
                                      rd_ff.slave, 1'b0);
               lost_cnt_in = lost_cnt_ff + 1'b1;
            end
         end else begin
            if (match && !hit_vld_ff) begin
               hit_vld_in = 1'b1;
               hit_idx_in = ev_idx_ff;
               hit_in     = rd_ff;
            end
            if (!ev_live && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = ev_idx_ff;
            end
         end
      end

      if (in_wrap) begin
         rsp_valid_in = 1'b1;
         case (req_ff.cmd)
            CMD_ANNOUNCE: begin
               if (def_ann) begin
                  rsp_in = make_rsp(KIND_DEFEND, self_uid_ff, self_mac_ff, 8'd0, 1'b0, 1'b1);
               end else if (hit_vld_ff || free_vld_ff) begin
                  mem_we = 1'b1;
                  mem_wa = hit_vld_ff ? hit_idx_ff : free_idx_ff;
                  valid_in[mem_wa] = 1'b1;
                  rsp_in = make_rsp(hit_vld_ff ? KIND_REFRESHED : KIND_DISCOVERED,
                                    req_ff.uid, req_ff.mac, req_ff.dev_code,
                                    req_ff.clock_slave, 1'b1);
               end else begin
                  rsp_in = make_rsp(KIND_FULL, req_ff.uid, req_ff.mac, req_ff.dev_code,
                                    req_ff.clock_slave, 1'b1);
               end
            end
            CMD_PROBE: begin
               if (def_probe) begin
                  rsp_in = make_rsp(KIND_DEFEND, self_uid_ff, self_mac_ff, 8'd0, 1'b0, 1'b1);
               end else begin
                  rsp_in = make_rsp(KIND_NOTHING, 16'd0, 48'd0, 8'd0, 1'b0, 1'b1);
               end
            end
            CMD_SWEEP: begin
               if (pend_vld_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = make_rsp(KIND_NOTHING, 16'd0, 48'd0, 8'd0, 1'b0, 1'b1);
               end
               pend_vld_in = 1'b0;
            end
            default: begin
               if (hit_vld_ff) begin
                  rsp_in = make_rsp(KIND_HIT, hit_ff.uid, hit_ff.mac, hit_ff.dev_code,
                                    hit_ff.slave, 1'b1);
               end else begin
                  rsp_in = make_rsp(KIND_MISS, req_ff.uid, 48'd0, 8'd0, 1'b0, 1'b1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= slot_mem[scan_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         scan_ff      <= '0;
         ev_vld_ff    <= 1'b0;
         hit_vld_ff   <= 1'b0;
         free_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         lost_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         scan_ff      <= scan_in;
         ev_vld_ff    <= ev_vld_in;
         hit_vld_ff   <= hit_vld_in;
         free_vld_ff  <= free_vld_in;
         pend_vld_ff  <= pend_vld_in;
         lost_cnt_ff  <= lost_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      ev_idx_ff   <= ev_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ff      <= hit_in;
      free_idx_ff <= free_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         self_uid_ff <= 16'd0;
         self_mac_ff <= 48'd0;
         expiry_ff   <= EXPIRY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SELF_UID: self_uid_ff <= csr_wdata[15:0];
            CSR_SELF_MAC: self_mac_ff <= csr_wdata[47:0];
            CSR_EXPIRY:   expiry_ff   <= csr_wdata[31:0];
            default:      ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> state_ff == ST_IDLE)
      else $error("final word while item still in progress");

   a_early_word_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> req_ff.cmd == CMD_SWEEP && state_ff != ST_IDLE)
      else $error("non-final word outside a sweep");

   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      ev_vld_ff |-> state_ff == ST_SCAN)
      else $error("slot evaluated outside scan");

   a_refresh_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRAP && req_ff.cmd == CMD_ANNOUNCE && hit_vld_ff |-> valid_ff[hit_idx_ff])
      else $error("refresh of an empty slot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

endmodule
